// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL; included by cfd_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-8 byte update shared by the frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned CFG_AW = 4;

    localparam logic [1:0] REG_START_MARKER = 2'd0;
    localparam logic [1:0] REG_END_MARKER   = 2'd1;
    localparam logic [1:0] REG_MAX_LEN      = 2'd2;

    localparam logic [7:0] RST_START_MARKER = 8'h02;
    localparam logic [7:0] RST_END_MARKER   = 8'h03;
    localparam logic [7:0] RST_MAX_LEN      = 8'hFF;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [9:0] MIN_FRAME  = 10'd5;
    localparam logic [8:0] COUNT_MAX  = 9'h1FF;
    // start + command + length ahead of the payload
    localparam logic [9:0] HDR_BYTES  = 10'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_CMD,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRC,
        PH_END,
        PH_DISCARD,
        PH_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4,
        ST_BAD_END   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        logic [2:0] status;
        logic [7:0] command;
        logic [7:0] payload_length;
    } t_out_item;

    // One byte through CRC-8, MSB first, unrolled.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- design/cfd_ifs.sv -----
// ----------------------------------------------------------------------------
// cfd stream interfaces
// Valid/ready channels for received bytes and for decoder results.
// ----------------------------------------------------------------------------
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [2:0] status;
    logic [7:0] command;
    logic [7:0] payload_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_done, output status, output command,
                    output payload_length, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_done, input status, input command,
                    input payload_length, output ready);
endinterface

// ----- design/cfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// APB register file: start marker, end marker, maximum payload length.
// ----------------------------------------------------------------------------
module cfd_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cfd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output cfd_pkg::t_cfg             o_cfg
);

    cfd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= cfd_pkg::RST_START_MARKER;
            r_cfg.end_marker   <= cfd_pkg::RST_END_MARKER;
            r_cfg.max_len      <= cfd_pkg::RST_MAX_LEN;
        end else if (wr_en) begin
            case (reg_idx)
                cfd_pkg::REG_START_MARKER: r_cfg.start_marker <= pwdata[7:0];
                cfd_pkg::REG_END_MARKER:   r_cfg.end_marker   <= pwdata[7:0];
                cfd_pkg::REG_MAX_LEN:      r_cfg.max_len      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cfd_pkg::REG_START_MARKER: prdata = {24'd0, r_cfg.start_marker};
            cfd_pkg::REG_END_MARKER:   prdata = {24'd0, r_cfg.end_marker};
            cfd_pkg::REG_MAX_LEN:      prdata = {24'd0, r_cfg.max_len};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ----- design/cfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module cfd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfd_in_if.sink            i_rx,
    input  logic              i_take,
    output logic              o_valid,
    output cfd_pkg::t_in_item o_item
);

    logic              r_valid;
    cfd_pkg::t_in_item r_item;
    logic              accept;

    // free slot, or the held item leaves this cycle
    assign i_rx.ready = !r_valid || i_take;
    assign accept     = i_rx.valid && i_rx.ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.rx_byte   <= i_rx.rx_byte;
            r_item.chunk_end <= i_rx.chunk_end;
        end
    end

endmodule

// ----- design/cfd_parser.sv -----
// ----------------------------------------------------------------------------
// cfd_parser
// Frame state, byte-wide CRC update and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfd_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  cfd_pkg::t_in_item  i_in,
    output logic               o_in_take,
    output logic               o_res_valid,
    output cfd_pkg::t_out_item o_res,
    input  logic               i_res_ready
);

    cfd_pkg::t_phase    r_phase, n_phase;
    logic [8:0]         r_bytes_seen, n_bytes_seen;
    logic [7:0]         r_crc, n_crc;
    logic [7:0]         r_cmd, n_cmd;
    logic [7:0]         r_len, n_len;
    cfd_pkg::t_status   r_err, n_err;
    logic               r_out_valid;
    cfd_pkg::t_out_item r_out, n_out;

    logic             fire;
    logic             pv;
    logic             done;
    logic             res_valid;
    cfd_pkg::t_status st;
    logic [9:0]       idx_p1;
    logic [9:0]       pay_end;
    logic [7:0]       crc_next;
    logic [7:0]       b;
    logic             last;

    assign fire      = i_in_valid && (!r_out_valid || i_res_ready);
    assign o_in_take = fire;
    assign b         = i_in.rx_byte;
    assign last      = i_in.chunk_end;
    assign idx_p1    = {1'b0, r_bytes_seen} + 10'd1;
    assign pay_end   = {2'b00, r_len} + cfd_pkg::HDR_BYTES;
    assign crc_next  = cfd_pkg::crc8_byte(r_crc, b);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_seen = r_bytes_seen;
        n_crc        = r_crc;
        n_cmd        = r_cmd;
        n_len        = r_len;
        n_err        = r_err;
        pv           = 1'b0;
        done         = 1'b0;
        st           = cfd_pkg::ST_OK;

        case (r_phase)
            cfd_pkg::PH_START: begin
                if (b != i_cfg.start_marker) begin
                    n_err = cfd_pkg::ST_BAD_START;
                end
                n_phase = cfd_pkg::PH_CMD;
            end
            cfd_pkg::PH_CMD: begin
                n_cmd   = b;
                n_crc   = crc_next;
                n_phase = cfd_pkg::PH_LEN;
            end
            cfd_pkg::PH_LEN: begin
                n_len = b;
                n_crc = crc_next;
                if (r_err == cfd_pkg::ST_OK && b > i_cfg.max_len) begin
                    n_err = cfd_pkg::ST_BAD_LEN;
                end
                if (n_err != cfd_pkg::ST_OK) begin
                    n_phase = cfd_pkg::PH_WAIT;
                end else if (b == 8'd0) begin
                    n_phase = cfd_pkg::PH_CRC;
                end else begin
                    n_phase = cfd_pkg::PH_PAYLOAD;
                end
            end
            cfd_pkg::PH_PAYLOAD: begin
                pv    = 1'b1;
                n_crc = crc_next;
                if (idx_p1 >= pay_end) begin
                    n_phase = cfd_pkg::PH_CRC;
                end
            end
            cfd_pkg::PH_CRC: begin
                if (b != r_crc) begin
                    n_err = cfd_pkg::ST_BAD_CRC;
                end
                n_phase = cfd_pkg::PH_END;
            end
            cfd_pkg::PH_END: begin
                done = 1'b1;
                if (r_err != cfd_pkg::ST_OK) begin
                    st = r_err;
                end else if (b == i_cfg.end_marker) begin
                    st = cfd_pkg::ST_OK;
                end else begin
                    st = cfd_pkg::ST_BAD_END;
                end
            end
            cfd_pkg::PH_WAIT: begin
                // bad start or length: status at the fifth byte
                if (idx_p1 >= cfd_pkg::MIN_FRAME) begin
                    done = 1'b1;
                    st   = r_err;
                end
            end
            default: ;
        endcase

        if (r_phase != cfd_pkg::PH_DISCARD) begin
            if (r_bytes_seen != cfd_pkg::COUNT_MAX) begin
                n_bytes_seen = r_bytes_seen + 9'd1;
            end
            if (!done && last) begin
                done = 1'b1;
                st   = (idx_p1 < cfd_pkg::MIN_FRAME) ? cfd_pkg::ST_SHORT
                                                     : cfd_pkg::ST_BAD_LEN;
            end
        end

        res_valid = (pv || done) && (r_phase != cfd_pkg::PH_DISCARD);

        n_out.payload_valid  = pv;
        n_out.payload_byte   = pv ? b : 8'd0;
        n_out.frame_done     = done;
        n_out.status         = done ? st : cfd_pkg::ST_OK;
        n_out.command        = done ? n_cmd : 8'd0;
        n_out.payload_length = done ? n_len : 8'd0;

        if (last) begin
            n_phase      = cfd_pkg::PH_START;
            n_bytes_seen = 9'd0;
            n_crc        = cfd_pkg::CRC_INIT;
            n_cmd        = 8'd0;
            n_len        = 8'd0;
            n_err        = cfd_pkg::ST_OK;
        end else if (done) begin
            n_phase = cfd_pkg::PH_DISCARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= cfd_pkg::PH_START;
            r_bytes_seen <= 9'd0;
            r_crc        <= cfd_pkg::CRC_INIT;
            r_cmd        <= 8'd0;
            r_len        <= 8'd0;
            r_err        <= cfd_pkg::ST_OK;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_bytes_seen <= n_bytes_seen;
            r_crc        <= n_crc;
            r_cmd        <= n_cmd;
            r_len        <= n_len;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `ASSERT_CLK(a_res_has_content, i_clk, i_rst_n, r_out_valid |-> (r_out.payload_valid || r_out.frame_done), "result item with neither payload nor status")
    `ASSERT_CLK(a_fields_clear_before_done, i_clk, i_rst_n, (r_out_valid && !r_out.frame_done) |-> (r_out.status == cfd_pkg::ST_OK && r_out.command == 8'd0 && r_out.payload_length == 8'd0), "status fields set on a payload-only item")
    `ASSERT_CLK(a_discard_silent, i_clk, i_rst_n, (fire && r_phase == cfd_pkg::PH_DISCARD) |=> !r_out_valid, "discarded byte produced a result")
    `ASSERT_CLK(a_chunk_end_restarts, i_clk, i_rst_n, (fire && last) |=> (r_phase == cfd_pkg::PH_START && r_bytes_seen == 9'd0 && r_err == cfd_pkg::ST_OK), "chunk end did not restart the parser")

endmodule

// ----- design/crc8_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// crc8_frame_decoder_core
// Framed byte-stream decoder with CRC-8 check; top level.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, sustained, whenever the result side keeps
// up; a byte passes the input register, then the parser's result register, on
// its way to the result port. The rate is set by the parser's step: byte-wide
// CRC-8 update and frame state change between the input register and the
// result register. Each chunk yields at most one status item, plus one item
// per payload byte; bytes after the status are dropped until chunk_end.
// Registers (APB, 4-byte stride): 0x0 start marker, 0x4 end marker, 0x8
// maximum payload length.
module crc8_frame_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cfd_in_if.sink                     i_rx,
    cfd_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    cfd_pkg::t_cfg      cfg;
    logic               in_valid;
    cfd_pkg::t_in_item  in_item;
    logic               in_take;
    logic               res_valid;
    cfd_pkg::t_out_item res;

    cfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (in_take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    cfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_take   (in_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_res.ready)
    );

    assign o_res.valid          = res_valid;
    assign o_res.payload_valid  = res.payload_valid;
    assign o_res.payload_byte   = res.payload_byte;
    assign o_res.frame_done     = res.frame_done;
    assign o_res.status         = res.status;
    assign o_res.command        = res.command;
    assign o_res.payload_length = res.payload_length;

endmodule
